[sv/cia_pkg.sv]
// Shared constants, opcodes and the pipeline transaction type of the complex integer ALU.
package cia_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int RES_WIDTH     = 33;
	// Width of a product and of a divide numerator/denominator magnitude.
	localparam int NW            = 2 * OPERAND_WIDTH;
	// Width of a sum of two products.
	localparam int SW            = NW + 1;
	// Working width before reduction into the result fields.
	localparam int XW            = (SW > RES_WIDTH) ? SW : RES_WIDTH;
	// Input register, products, combine, one divider stage per quotient bit, output.
	localparam int LATENCY       = NW + 4;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} cia_op_t;

	typedef struct packed {
		logic                 is_div;
		logic                 dz;
		logic                 neg_re;
		logic                 neg_im;
		logic [RES_WIDTH-1:0] res_re;
		logic [RES_WIDTH-1:0] res_im;
		logic [NW-1:0]        den;
		logic [NW-1:0]        nq_re;
		logic [NW-1:0]        nq_im;
		logic [NW-1:0]        rem_re;
		logic [NW-1:0]        rem_im;
	} cia_pkt_t;

endpackage

[sv/cia_front.sv]
// Front end: operand register, product stage and combine stage feeding the divider.
module cia_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  logic [1:0]                              op,
	input  logic signed [cia_pkg::OPERAND_WIDTH-1:0] a_re,
	input  logic signed [cia_pkg::OPERAND_WIDTH-1:0] a_im,
	input  logic signed [cia_pkg::OPERAND_WIDTH-1:0] b_re,
	input  logic signed [cia_pkg::OPERAND_WIDTH-1:0] b_im,
	output logic                                    vld,
	output cia_pkg::cia_pkt_t                       pkt
);
	import cia_pkg::*;

	localparam int W = OPERAND_WIDTH;

	logic                vld_s1, vld_s2, vld_s3;
	cia_op_t             op_s1, op_s2;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [NW-1:0] prr_s2, pii_s2, pri_s2, pir_s2, brr_s2, bii_s2;
	logic signed [W:0]   as_re_s2, as_im_s2;
	cia_pkt_t            pkt_s3;

	logic signed [SW-1:0] sum_re, sum_im, abs_re, abs_im;
	logic signed [XW-1:0] mul_re, mul_im, as_re_x, as_im_x;
	logic [NW-1:0]        den;
	cia_pkt_t             pkt_d;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: hold operands
	always_ff @(posedge clk) begin
		op_s1 <= cia_op_t'(op);
		ar_s1 <= a_re;
		ai_s1 <= a_im;
		br_s1 <= b_re;
		bi_s1 <= b_im;
	end

	// stage 2: products and part-wise add/subtract
	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		prr_s2 <= NW'(ar_s1) * NW'(br_s1);
		pii_s2 <= NW'(ai_s1) * NW'(bi_s1);
		pri_s2 <= NW'(ar_s1) * NW'(bi_s1);
		pir_s2 <= NW'(ai_s1) * NW'(br_s1);
		brr_s2 <= NW'(br_s1) * NW'(br_s1);
		bii_s2 <= NW'(bi_s1) * NW'(bi_s1);
		if (op_s1 == OP_SUB) begin
			as_re_s2 <= (W+1)'(ar_s1) - (W+1)'(br_s1);
			as_im_s2 <= (W+1)'(ai_s1) - (W+1)'(bi_s1);
		end else begin
			as_re_s2 <= (W+1)'(ar_s1) + (W+1)'(br_s1);
			as_im_s2 <= (W+1)'(ai_s1) + (W+1)'(bi_s1);
		end
	end

	// stage 3: combine products, prepare the divide
	always_comb begin
		sum_re  = SW'(prr_s2) + SW'(pii_s2);
		sum_im  = SW'(pir_s2) - SW'(pri_s2);
		abs_re  = sum_re[SW-1] ? -sum_re : sum_re;
		abs_im  = sum_im[SW-1] ? -sum_im : sum_im;
		mul_re  = XW'(prr_s2) - XW'(pii_s2);
		mul_im  = XW'(pri_s2) + XW'(pir_s2);
		as_re_x = XW'(as_re_s2);
		as_im_x = XW'(as_im_s2);
		den     = $unsigned(brr_s2) + $unsigned(bii_s2);

		pkt_d        = '0;
		pkt_d.is_div = (op_s2 == OP_DIV);
		pkt_d.dz     = (op_s2 == OP_DIV) && (den == '0);
		pkt_d.neg_re = sum_re[SW-1];
		pkt_d.neg_im = sum_im[SW-1];
		pkt_d.den    = den;
		pkt_d.nq_re  = abs_re[NW-1:0];
		pkt_d.nq_im  = abs_im[NW-1:0];
		case (op_s2)
			OP_ADD, OP_SUB: begin
				pkt_d.res_re = as_re_x[RES_WIDTH-1:0];
				pkt_d.res_im = as_im_x[RES_WIDTH-1:0];
			end
			OP_MUL: begin
				pkt_d.res_re = mul_re[RES_WIDTH-1:0];
				pkt_d.res_im = mul_im[RES_WIDTH-1:0];
			end
			default: begin
				pkt_d.res_re = '0;
				pkt_d.res_im = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		pkt_s3 <= pkt_d;
	end

	assign vld = vld_s3;
	assign pkt = pkt_s3;

endmodule

[sv/cia_div.sv]
// Pipelined restoring divider: two lanes share one denominator, one quotient bit per stage.
module cia_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  cia_pkg::cia_pkt_t pkt_in,
	output logic              vld_out,
	output cia_pkg::cia_pkt_t pkt_out
);
	import cia_pkg::*;

	logic     vld_s [NW];
	cia_pkt_t stg_s [NW];

	function automatic cia_pkt_t div_step(cia_pkt_t p);
		cia_pkt_t    r;
		logic [NW:0] t_re;
		logic [NW:0] t_im;
		logic [NW:0] d;
		r    = p;
		d    = {1'b0, p.den};
		t_re = {p.rem_re, p.nq_re[NW-1]};
		t_im = {p.rem_im, p.nq_im[NW-1]};
		if (t_re >= d) begin
			r.rem_re = NW'(t_re - d);
			r.nq_re  = {p.nq_re[NW-2:0], 1'b1};
		end else begin
			r.rem_re = t_re[NW-1:0];
			r.nq_re  = {p.nq_re[NW-2:0], 1'b0};
		end
		if (t_im >= d) begin
			r.rem_im = NW'(t_im - d);
			r.nq_im  = {p.nq_im[NW-2:0], 1'b1};
		end else begin
			r.rem_im = t_im[NW-1:0];
			r.nq_im  = {p.nq_im[NW-2:0], 1'b0};
		end
		return r;
	endfunction

	genvar k;
	generate
		for (k = 0; k < NW; k++) begin : g_stage
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= (k == 0) ? vld_in : vld_s[(k == 0) ? 0 : k-1];
				end
			end
			if (k == 0) begin : g_first
				always_ff @(posedge clk) begin
					stg_s[k] <= div_step(pkt_in);
				end
			end else begin : g_rest
				always_ff @(posedge clk) begin
					stg_s[k] <= div_step(stg_s[k-1]);
				end
			end
		end
	endgenerate

	assign vld_out = vld_s[NW-1];
	assign pkt_out = stg_s[NW-1];

endmodule

[sv/complex_integer_alu_core.sv]
// Top level of the complex integer ALU: front end, divider pipeline and output register.
//
// Complex integer ALU. Each transaction carries two complex operands with
// signed OPERAND_WIDTH-bit parts and an opcode (add, subtract, multiply,
// divide) and yields exactly one result. A transaction is taken whenever
// start is high; busy is always low, so a new one may be issued every cycle.
// Every result appears on res_re/res_im/div_zero for exactly one cycle with
// done high, in issue order, for all opcodes. The divider resolves one
// quotient bit per pipeline stage. Division multiplies by the conjugate of
// the divisor and divides by its squared magnitude, truncating toward zero;
// a zero divisor returns zero and raises div_zero. The receiver cannot stall
// the output; results must be captured in the cycle done is high.
module complex_integer_alu_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic [1:0]                               op,
	input  logic signed [cia_pkg::OPERAND_WIDTH-1:0] a_re,
	input  logic signed [cia_pkg::OPERAND_WIDTH-1:0] a_im,
	input  logic signed [cia_pkg::OPERAND_WIDTH-1:0] b_re,
	input  logic signed [cia_pkg::OPERAND_WIDTH-1:0] b_im,
	output logic                                     done,
	output logic signed [cia_pkg::RES_WIDTH-1:0]     res_re,
	output logic signed [cia_pkg::RES_WIDTH-1:0]     res_im,
	output logic                                     div_zero
);
	import cia_pkg::*;

	logic     accept;
	logic     front_vld, div_vld;
	cia_pkt_t front_pkt, div_pkt;

	logic signed [XW-1:0] q_re_x, q_im_x;
	logic [RES_WIDTH-1:0] fin_re, fin_im;

	logic                 done_q, dz_q;
	logic [RES_WIDTH-1:0] res_re_q, res_im_q;

	// The pipeline never stalls, so every start is a transaction.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	cia_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (op),
		.a_re   (a_re),
		.a_im   (a_im),
		.b_re   (b_re),
		.b_im   (b_im),
		.vld    (front_vld),
		.pkt    (front_pkt)
	);

	cia_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (front_vld),
		.pkt_in  (front_pkt),
		.vld_out (div_vld),
		.pkt_out (div_pkt)
	);

	// Apply the quotient sign, then pick divide or pass-through result.
	always_comb begin
		q_re_x = XW'($signed({1'b0, div_pkt.nq_re}));
		q_im_x = XW'($signed({1'b0, div_pkt.nq_im}));
		if (div_pkt.neg_re) begin
			q_re_x = -q_re_x;
		end
		if (div_pkt.neg_im) begin
			q_im_x = -q_im_x;
		end
		if (!div_pkt.is_div) begin
			fin_re = div_pkt.res_re;
			fin_im = div_pkt.res_im;
		end else if (div_pkt.dz) begin
			fin_re = '0;
			fin_im = '0;
		end else begin
			fin_re = q_re_x[RES_WIDTH-1:0];
			fin_im = q_im_x[RES_WIDTH-1:0];
		end
	end

	// Output register: one-cycle strobe per result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		res_re_q <= fin_re;
		res_im_q <= fin_im;
		dz_q     <= div_pkt.dz;
	end

	assign done     = done_q;
	assign res_re   = $signed(res_re_q);
	assign res_im   = $signed(res_im_q);
	assign div_zero = dz_q;

`ifndef SYNTHESIS
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_zero) |-> (res_re == '0 && res_im == '0))
		else $error("div_zero result is not zero");

	a_lat_hit: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result missing at fixed latency");

	a_lat_none: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LATENCY !done)
		else $error("result without transaction");

	a_dz_op: assert property (@(posedge clk) disable iff (!arst_n)
		(start && op != OP_DIV) |-> ##LATENCY !div_zero)
		else $error("div_zero on non-divide");
`endif

endmodule

[test/tb_complex_integer_alu_core.sv]
// Self-checking testbench for the complex integer ALU core.
module tb_complex_integer_alu_core;

	import cia_pkg::*;

	localparam int W = OPERAND_WIDTH;
	localparam longint RESULT_MASK = (64'd1 << RES_WIDTH) - 1;

	// Expected result of one transaction, kept in issue order.
	typedef struct {
		logic [RES_WIDTH-1:0] re;
		logic [RES_WIDTH-1:0] im;
		logic                 dz;
	} cplx_result_t;

	// Scoreboard: predict each issued operation and check results in order.
	class cplx_scoreboard;
		cplx_result_t pending[$];
		int errors;

		// Truncating quotient of a signed numerator by a positive denominator.
		function automatic logic [RES_WIDTH-1:0] trunc_div(longint num, longint den);
			longint mag;
			mag = (num < 0 ? -num : num) / den;
			return RES_WIDTH'((num < 0 ? -mag : mag) & RESULT_MASK);
		endfunction

		function void note_issue(cia_op_t opc, logic signed [W-1:0] ar, logic signed [W-1:0] ai,
				logic signed [W-1:0] br, logic signed [W-1:0] bi);
			cplx_result_t r;
			longint xr, xi, yr, yi, den;
			xr = ar; xi = ai; yr = br; yi = bi;
			r.dz = 1'b0;
			case (opc)
				OP_ADD: begin
					r.re = RES_WIDTH'((xr + yr) & RESULT_MASK);
					r.im = RES_WIDTH'((xi + yi) & RESULT_MASK);
				end
				OP_SUB: begin
					r.re = RES_WIDTH'((xr - yr) & RESULT_MASK);
					r.im = RES_WIDTH'((xi - yi) & RESULT_MASK);
				end
				OP_MUL: begin
					r.re = RES_WIDTH'((xr * yr - xi * yi) & RESULT_MASK);
					r.im = RES_WIDTH'((xr * yi + xi * yr) & RESULT_MASK);
				end
				default: begin
					den = yr * yr + yi * yi;
					if (den == 0) begin
						r.re = '0;
						r.im = '0;
						r.dz = 1'b1;
					end else begin
						r.re = trunc_div(xr * yr + xi * yi, den);
						r.im = trunc_div(xi * yr - xr * yi, den);
					end
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(logic [RES_WIDTH-1:0] re, logic [RES_WIDTH-1:0] im, logic dz);
			cplx_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result re=%h im=%h dz=%b", re, im, dz);
				return;
			end
			e = pending.pop_front();
			if (re !== e.re || im !== e.im || dz !== e.dz) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected re=%h im=%h dz=%b, got re=%h im=%h dz=%b",
						e.re, e.im, e.dz, re, im, dz);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, div_zero;
	logic [1:0] op;
	logic signed [W-1:0] a_re, a_im, b_re, b_im;
	logic signed [RES_WIDTH-1:0] res_re, res_im;

	cplx_scoreboard sb;
	longint cycles = 0;

	complex_integer_alu_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.done(done), .res_re(res_re), .res_im(res_im), .div_zero(div_zero)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Check every strobed result at the rising edge; also bound the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			sb.check_result(res_re, res_im, div_zero);
		if (cycles > 200000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Pick an operand part, weighted toward the extremes and zero.
	function automatic logic [W-1:0] pick_part();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(W-1){1'b0}}};
			1: return {1'b0, {(W-1){1'b1}}};
			2: return '0;
			3: return W'($urandom_range(0, 7) - 4);
			default: return W'($urandom);
		endcase
	endfunction

	// Issue one transaction: hold start high until an edge accepts it.
	task automatic issue(cia_op_t opc, logic [W-1:0] ar, logic [W-1:0] ai,
			logic [W-1:0] br, logic [W-1:0] bi);
		start <= 1'b1;
		op    <= opc;
		a_re  <= ar;
		a_im  <= ai;
		b_re  <= br;
		b_im  <= bi;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_issue(opc, ar, ai, br, bi);
		@(negedge clk);
	endtask

	// Drop start for a number of cycles.
	task automatic gap(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

	initial begin
		int burst, wait_n;
		cia_op_t opc;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_ADD;
		a_re = '0; a_im = '0; b_re = '0; b_im = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes for every operation, zero divisor, sign cases.
		for (int o = 0; o < 4; o++) begin
			opc = cia_op_t'(o);
			issue(opc, MAXV, MAXV, MAXV, MAXV);
			issue(opc, MINV, MINV, MINV, MINV);
			issue(opc, MINV, MAXV, MAXV, MINV);
			issue(opc, MAXV, MINV, MINV, MAXV);
		end
		issue(OP_DIV, 16'sd5, -16'sd7, '0, '0);
		issue(OP_DIV, MINV, MINV, '0, '0);
		issue(OP_DIV, -16'sd7, 16'sd3, 16'sd2, '0);
		issue(OP_DIV, 16'sd7, -16'sd3, '0, -16'sd2);
		issue(OP_MUL, '0, '0, '0, '0);
		issue(OP_DIV, 16'sd1, 16'sd1, MINV, MINV);
		gap(3);

		// Random: bursts of back-to-back issues with random gaps between.
		for (int n = 0; n < 850; ) begin
			burst = $urandom_range(1, 30);
			for (int k = 0; k < burst; k++, n++) begin
				opc = cia_op_t'($urandom_range(0, 3));
				issue(opc, pick_part(), pick_part(), pick_part(), pick_part());
			end
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (wait_n > 0)
				gap(wait_n);
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
sv/cia_pkg.sv
sv/cia_front.sv
sv/cia_div.sv
sv/complex_integer_alu_core.sv
test/tb_complex_integer_alu_core.sv
